// File: sv/svpe_pkg.sv
`timescale 1ns / 1ps

package svpe_pkg;

   localparam int ReqDataWidth = 104;
   localparam int RspDataWidth = 104;
   localparam int BaseWidth    = 23;
   localparam int RemWidth     = 24;
   localparam int QuotBits     = 12;

   localparam logic [BaseWidth-1:0] TOP_BASE   = 23'd5644800;
   localparam logic signed [3:0]    OCT_TOP    = 4'sd7;
   localparam logic signed [3:0]    OCT_BOTTOM = -4'sd8;
   localparam logic [3:0]           DIV_FIRST  = 4'(QuotBits - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NORM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic norm_en;
      logic div_init;
      logic div_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic norm_stop;
      logic div_last;
   } status_type;

   localparam logic [7:0] ATT_ROM [256] = '{
      8'd255, 8'd127, 8'd111, 8'd102, 8'd95, 8'd90, 8'd86, 8'd82,
      8'd79, 8'd77, 8'd74, 8'd72, 8'd70, 8'd68, 8'd66, 8'd65,
      8'd63, 8'd62, 8'd61, 8'd59, 8'd58, 8'd57, 8'd56, 8'd55,
      8'd54, 8'd53, 8'd52, 8'd51, 8'd50, 8'd50, 8'd49, 8'd48,
      8'd47, 8'd47, 8'd46, 8'd45, 8'd45, 8'd44, 8'd43, 8'd43,
      8'd42, 8'd42, 8'd41, 8'd41, 8'd40, 8'd40, 8'd39, 8'd39,
      8'd38, 8'd38, 8'd37, 8'd37, 8'd36, 8'd36, 8'd35, 8'd35,
      8'd34, 8'd34, 8'd34, 8'd33, 8'd33, 8'd33, 8'd32, 8'd32,
      8'd31, 8'd31, 8'd31, 8'd30, 8'd30, 8'd30, 8'd29, 8'd29,
      8'd29, 8'd28, 8'd28, 8'd28, 8'd27, 8'd27, 8'd27, 8'd27,
      8'd26, 8'd26, 8'd26, 8'd25, 8'd25, 8'd25, 8'd25, 8'd24,
      8'd24, 8'd24, 8'd24, 8'd23, 8'd23, 8'd23, 8'd23, 8'd22,
      8'd22, 8'd22, 8'd22, 8'd21, 8'd21, 8'd21, 8'd21, 8'd20,
      8'd20, 8'd20, 8'd20, 8'd20, 8'd19, 8'd19, 8'd19, 8'd19,
      8'd18, 8'd18, 8'd18, 8'd18, 8'd18, 8'd17, 8'd17, 8'd17,
      8'd17, 8'd17, 8'd17, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
      8'd15, 8'd15, 8'd15, 8'd15, 8'd15, 8'd15, 8'd14, 8'd14,
      8'd14, 8'd14, 8'd14, 8'd14, 8'd13, 8'd13, 8'd13, 8'd13,
      8'd13, 8'd13, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12,
      8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd10,
      8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd9, 8'd9,
      8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd8, 8'd8, 8'd8,
      8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd7, 8'd7, 8'd7,
      8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd6, 8'd6, 8'd6,
      8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd5, 8'd5, 8'd5,
      8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd4, 8'd4,
      8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd3,
      8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
      8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
      8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

endpackage

// File: sv/svpe_dp.sv
`timescale 1ns / 1ps

module svpe_dp (
   input  logic                                  clock,
   input  svpe_pkg::cmd_type                     cmd,
   output svpe_pkg::status_type                  status,
   input  logic [svpe_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic [svpe_pkg::RspDataWidth-1:0]     rsp_tdata
);

   logic [5:0]  chan_ff;
   logic [20:0] addr_ff;
   logic [1:0]  fmt_ff;
   logic [15:0] lst_ff;
   logic [15:0] lend_ff;
   logic [21:0] rate_ff;
   logic [7:0]  vol_ff;
   logic [7:0]  pan_ff;
   logic        loop_ff;
   logic        hold_ff;

   logic [svpe_pkg::BaseWidth-1:0] base_ff;
   logic signed [3:0]              oct_ff;
   logic [svpe_pkg::RemWidth-1:0]  rem_ff;
   logic [9:0]                     quot_ff;
   logic [3:0]                     cnt_ff;
   logic [svpe_pkg::RspDataWidth-1:0] out_ff;

   logic [svpe_pkg::RemWidth-1:0]  rem_shift;
   logic                           rem_ge;
   logic                           next_bit;
   logic [15:0]                    ctrl_word;
   logic [4:0]                     pan_code;
   logic [7:0]                     attenuation;

   always_comb begin
      unique case (cnt_ff)
         4'd11: next_bit = rate_ff[1];
         4'd10: next_bit = rate_ff[0];
         default: next_bit = 1'b0;
      endcase
      rem_shift = {rem_ff[svpe_pkg::RemWidth-2:0], next_bit};
      rem_ge = rem_shift >= {1'b0, base_ff};

      status.norm_stop = ({1'b0, rate_ff} >= base_ff) || (oct_ff == svpe_pkg::OCT_BOTTOM);
      status.div_last = cnt_ff == 4'd0;

      ctrl_word = {{2{~hold_ff}}, 4'b0000, loop_ff, fmt_ff, 2'b00, addr_ff[20:16]};
      pan_code = pan_ff[7] ? {1'b0, pan_ff[6:3]} : {1'b1, ~pan_ff[6:3]};
      attenuation = svpe_pkg::ATT_ROM[vol_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         chan_ff <= req_tdata[5:0];
         addr_ff <= req_tdata[26:6];
         fmt_ff <= req_tdata[28:27];
         lst_ff <= req_tdata[44:29];
         lend_ff <= req_tdata[60:45];
         rate_ff <= req_tdata[82:61];
         vol_ff <= req_tdata[90:83];
         pan_ff <= req_tdata[98:91];
         loop_ff <= req_tdata[99];
         hold_ff <= req_tdata[100];
         base_ff <= svpe_pkg::TOP_BASE;
         oct_ff <= svpe_pkg::OCT_TOP;
      end
      if (cmd.norm_en) begin
         base_ff <= base_ff >> 1;
         oct_ff <= oct_ff - 4'sd1;
      end
      if (cmd.div_init) begin
         rem_ff <= svpe_pkg::RemWidth'(rate_ff[21:2]);
         quot_ff <= '0;
         cnt_ff <= svpe_pkg::DIV_FIRST;
      end
      if (cmd.div_en) begin
         rem_ff <= rem_ge ? rem_shift - {1'b0, base_ff} : rem_shift;
         quot_ff <= {quot_ff[8:0], rem_ge};
         cnt_ff <= cnt_ff - 4'd1;
      end
      if (cmd.out_load) begin
         out_ff <= {7'b0000000, attenuation, pan_code, quot_ff, oct_ff,
                    lend_ff, lst_ff, addr_ff[15:0], ctrl_word, chan_ff};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

// File: sv/svpe_ctrl.sv
`timescale 1ns / 1ps

module svpe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  svpe_pkg::status_type status,
   output svpe_pkg::cmd_type    cmd
);

   svpe_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svpe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         svpe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = svpe_pkg::ST_NORM;
            end
         end
         svpe_pkg::ST_NORM: begin
            if (status.norm_stop) begin
               cmd.div_init = 1'b1;
               state_in = svpe_pkg::ST_DIV;
            end else begin
               cmd.norm_en = 1'b1;
            end
         end
         svpe_pkg::ST_DIV: begin
            cmd.div_en = 1'b1;
            if (status.div_last) begin
               state_in = svpe_pkg::ST_OUT;
            end
         end
         svpe_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = svpe_pkg::ST_IDLE;
            end
         end
         default: state_in = svpe_pkg::ST_IDLE;
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("A waiting result was overwritten.");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == svpe_pkg::ST_NORM))
      else $error("An accepted transfer did not start normalization.");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("Result became valid without an output load.");

endmodule

// File: sv/sound_voice_param_encoder.sv
`timescale 1ns / 1ps
// Channel   Direction  Width  Contents
// req_      in         104    one voice set-up request
// rsp_      out        104    encoded channel register words
//
// An item passes from one accepted transfer to the next through these steps: the
// accept, the octave steps of the normalizing loop plus a final check, twelve
// quotient bits from the restoring divider, and the load of the output register.
// Reset clears the controller and the result valid flag.
// A new request is taken once the previous one has been loaded into the output
// register; a result not yet taken only holds the final output load.

module sound_voice_param_encoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // channel, sample_addr, sample_format, loop_start, loop_end, rate_hz,
   // volume, pan, loop_enable, hold_key_off, zero fill
   input  logic [svpe_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // channel_out, ctrl_word, addr_low_word, loop_start_word, loop_end_word,
   // octave, mantissa, pan_code, attenuation, zero fill
   output logic [svpe_pkg::RspDataWidth-1:0]     rsp_tdata
);

   svpe_pkg::cmd_type    cmd;
   svpe_pkg::status_type status;

   svpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   svpe_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
